// ===== rtl/tmks_pkg.sv =====
// tile maximum keypoint select: shared types and constants
// used by tmks_front, tmks_back and the top level, no dependencies
`default_nettype none

package tmks_pkg;

    localparam int RESP_W    = 16;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int TILE_W    = 7;
    localparam int IN_TILE_W = 6;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [TILE_W-1:0] TILE_RESET   = 7'd21;
    localparam logic [TILE_W-1:0] TILE_MIN     = 7'd8;
    localparam logic [TILE_W-1:0] TILE_MAX     = 7'd64;

    // register word index, taken from paddr[3:2]
    localparam int ADDR_W   = 4;
    localparam int REG_IX_W = 2;
    localparam logic [REG_IX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IX_W-1:0] REG_TILE_SIZE    = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [TILE_W-1:0] tile_size;
    } cfg_t;

    // one classified pixel on its way from the front to the back
    typedef struct packed {
        logic               first;
        logic               last;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [RESP_W-1:0]  resp;
    } pix_t;

    // tile memory word and result word, x in the lowest bits
    typedef struct packed {
        logic [RESP_W-1:0]  strength;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } corner_t;

endpackage

`default_nettype wire

// ===== rtl/tmks_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tmks_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tmks_queue.sv =====
// short fifo between the pixel front end and the tile update back end
// depends on nothing but its parameters
`default_nettype none

module tmks_queue #(
    parameter int DATA_W = 50,
    parameter int DEPTH  = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   ready,
    input  wire logic              pop,
    output logic                   pop_valid,
    output logic      [DATA_W-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && ready;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    property p_count_bounded;
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH);
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("queue count above depth");

    property p_count_tracks;
        @(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1));
    endproperty
    a_count_tracks: assert property (p_count_tracks)
        else $error("queue count lost a push");

    property p_pointers_agree;
        @(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg);
    endproperty
    a_pointers_agree: assert property (p_pointers_agree)
        else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ===== rtl/tmks_front.sv =====
// pixel front end: frame and tile position counters, classifies each pixel
// depends on tmks_pkg
`default_nettype none

module tmks_front #(
    parameter int MAX_WIDTH        = 4096,
    parameter int MAX_HEIGHT       = 4096,
    parameter int MAX_TILE_COLUMNS = 512
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tmks_pkg::cfg_t                      cfg,
    input  wire logic                                restart,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tmks_pkg::RESP_W-1:0]         s_tdata,
    input  wire logic                                q_ready,
    output logic                                     push,
    output logic      [$clog2(MAX_TILE_COLUMNS)-1:0] push_idx,
    output tmks_pkg::pix_t                           push_pix
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;
    localparam int IW = $clog2(MAX_TILE_COLUMNS);
    localparam int TW = tmks_pkg::TILE_W;
    localparam int TIW = tmks_pkg::IN_TILE_W;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [TIW-1:0] cit_reg, cit_next;
    logic [TIW-1:0] rit_reg, rit_next;
    logic [IW-1:0]  tcol_reg, tcol_next;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [TW-1:0] t;
    logic          row_end, tcol_end, frame_bottom, trow_end;
    logic          accept;

    // clamp the geometry registers into range
    always_comb
    begin
        if (cfg.image_width == '0)
        begin
            w = WW'(1);
        end
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(cfg.image_width);
        end

        if (cfg.image_height == '0)
        begin
            h = HW'(1);
        end
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
        begin
            h = HW'(MAX_HEIGHT);
        end
        else
        begin
            h = HW'(cfg.image_height);
        end

        if (cfg.tile_size < tmks_pkg::TILE_MIN)
        begin
            t = tmks_pkg::TILE_MIN;
        end
        else if (cfg.tile_size > tmks_pkg::TILE_MAX)
        begin
            t = tmks_pkg::TILE_MAX;
        end
        else
        begin
            t = cfg.tile_size;
        end
    end

    assign row_end      = (WW'(col_reg) + WW'(1)) >= w;
    assign tcol_end     = row_end || ((TW'(cit_reg) + TW'(1)) >= t);
    assign frame_bottom = (HW'(row_reg) + HW'(1)) >= h;
    assign trow_end     = frame_bottom || ((TW'(rit_reg) + TW'(1)) >= t);

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign push     = accept;
    assign push_idx = tcol_reg;

    always_comb
    begin
        push_pix.first = (cit_reg == '0) && (rit_reg == '0);
        push_pix.last  = tcol_end && trow_end;
        push_pix.y     = tmks_pkg::COORD_W'(row_reg);
        push_pix.x     = tmks_pkg::COORD_W'(col_reg);
        push_pix.resp  = s_tdata;
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cit_next  = cit_reg;
        rit_next  = rit_reg;
        tcol_next = tcol_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            cit_next  = '0;
            rit_next  = '0;
            tcol_next = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_next  = '0;
                cit_next  = '0;
                tcol_next = '0;
                if (frame_bottom)
                begin
                    row_next = '0;
                    rit_next = '0;
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                    rit_next = trow_end ? '0 : rit_reg + TIW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                if (tcol_end)
                begin
                    cit_next = '0;
                    // extra tile columns share the last tile entry
                    if (tcol_reg != IW'(MAX_TILE_COLUMNS - 1))
                    begin
                        tcol_next = tcol_reg + IW'(1);
                    end
                end
                else
                begin
                    cit_next = cit_reg + TIW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cit_reg  <= '0;
            rit_reg  <= '0;
            tcol_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cit_reg  <= cit_next;
            rit_reg  <= rit_next;
            tcol_reg <= tcol_next;
        end
    end

    property p_col_in_frame;
        @(posedge clk) disable iff (!rst_n)
        (accept && !restart && !row_end) |=> (col_reg == $past(col_reg) + CW'(1));
    endproperty
    a_col_in_frame: assert property (p_col_in_frame)
        else $error("column counter skipped");

    property p_row_wrap;
        @(posedge clk) disable iff (!rst_n)
        (accept && row_end && frame_bottom) |=> (row_reg == '0 && col_reg == '0);
    endproperty
    a_row_wrap: assert property (p_row_wrap)
        else $error("frame did not restart at origin");

    property p_tile_origin;
        @(posedge clk) disable iff (!rst_n)
        (col_reg == '0) |-> (cit_reg == '0 && tcol_reg == '0);
    endproperty
    a_tile_origin: assert property (p_tile_origin)
        else $error("row start not at tile start");

endmodule

`default_nettype wire

// ===== rtl/tmks_back.sv =====
// tile update back end: read-modify-write of the per-tile best in the tile ram,
// forwarding of back-to-back updates and the result register
// depends on tmks_pkg and tmks_ram
`default_nettype none

module tmks_back #(
    parameter int MAX_TILE_COLUMNS = 512
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire logic [$clog2(MAX_TILE_COLUMNS)-1:0] q_idx,
    input  wire tmks_pkg::pix_t                      q_pix,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output tmks_pkg::corner_t                        m_tdata
);

    localparam int IW = $clog2(MAX_TILE_COLUMNS);

    logic                s1_valid_reg;
    logic [IW-1:0]       s1_idx_reg;
    tmks_pkg::pix_t      s1_pix_reg;
    logic                fwd_hit_reg;
    tmks_pkg::corner_t   fwd_data_reg;
    logic                m_valid_reg;
    tmks_pkg::corner_t   m_data_reg;

    tmks_pkg::corner_t   rdata;
    tmks_pkg::corner_t   base;
    tmks_pkg::corner_t   best;
    logic                emit;
    logic                out_free;
    logic                s1_go;

    tmks_ram #(
        .WIDTH ($bits(tmks_pkg::corner_t)),
        .DEPTH (MAX_TILE_COLUMNS)
    ) u_tile_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_idx_reg),
        .wdata (best),
        .re    (pop),
        .raddr (q_idx),
        .rdata (rdata)
    );

    // tile best so far: cleared on the tile's first pixel, otherwise the
    // update written in the cycle this read went out, otherwise the ram
    always_comb
    begin
        if (s1_pix_reg.first)
        begin
            base.strength = '0;
            base.y        = s1_pix_reg.y;
            base.x        = s1_pix_reg.x;
        end
        else if (fwd_hit_reg)
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rdata;
        end

        if (s1_pix_reg.resp > base.strength)
        begin
            best.strength = s1_pix_reg.resp;
            best.y        = s1_pix_reg.y;
            best.x        = s1_pix_reg.x;
        end
        else
        begin
            best = base;
        end
    end

    assign emit     = s1_pix_reg.last && (best.strength != '0);
    assign out_free = !m_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && (!emit || out_free);
    assign pop      = q_valid && (!s1_valid_reg || s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_go && (s1_idx_reg == q_idx);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_idx_reg   <= q_idx;
            s1_pix_reg   <= q_pix;
            fwd_data_reg <= best;
        end
        if (s1_go && emit)
        begin
            m_data_reg <= best;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    property p_result_nonzero;
        @(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg.strength != '0);
    endproperty
    a_result_nonzero: assert property (p_result_nonzero)
        else $error("result with zero strength");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n)
        (s1_go && emit) |-> out_free;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("result register overwritten");

    property p_stall_holds;
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_idx_reg) && !$past(pop));
    endproperty
    a_stall_holds: assert property (p_stall_holds)
        else $error("update stage moved while stalled");

endmodule

`default_nettype wire

// ===== rtl/tile_maximum_keypoint_select.sv =====
// tile maximum keypoint select, top level
// takes a corner-response frame one pixel per transfer in raster order on s_*,
// and returns per square tile the first strongest pixel on m_*.
// registers (apb, pready always high): 0x0 image_width, 0x4 image_height,
// 0x8 tile_size; a write to any of these three restarts the frame at pixel (0,0).
// a tile is reported when its bottom-right pixel arrives (clipped at the right
// and bottom edges), only if its best response is nonzero, in tile raster order.
// throughput: one pixel per cycle unless a stalled result holds the flow. a tile's
// last pixel goes through the input queue, then the tile ram read, then the result
// register, which drives m_tvalid and m_tdata.
// a stalled m_tready holds the result; pixels keep flowing while the next
// result is not due, and up to four pixels queue ahead of the tile ram update.
// reset returns the registers to 640 x 480 with tile size 21, empties the queue
// and the result register and starts at pixel (0,0); the tile ram needs no clear.
// depends on tmks_pkg, tmks_front, tmks_queue, tmks_back, tmks_ram
`default_nettype none

module tile_maximum_keypoint_select #(
    parameter int MAX_WIDTH        = 4096,
    parameter int MAX_HEIGHT       = 4096,
    parameter int MAX_TILE_COLUMNS = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tmks_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,   // [15:0] response
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [39:0]                   m_tdata    // [11:0] corner_x,
                                                          // [23:12] corner_y,
                                                          // [39:24] corner_strength
);

    localparam int IW = $clog2(MAX_TILE_COLUMNS);
    localparam int QW = IW + $bits(tmks_pkg::pix_t);

    tmks_pkg::cfg_t    cfg_reg, cfg_next;
    logic              cfg_wr;
    logic              restart;
    logic [tmks_pkg::REG_IX_W-1:0] reg_ix;

    logic              push;
    logic [IW-1:0]     push_idx;
    tmks_pkg::pix_t    push_pix;
    logic              q_ready;
    logic              pop;
    logic              q_valid;
    logic [QW-1:0]     q_data;
    logic [IW-1:0]     q_idx;
    tmks_pkg::pix_t    q_pix;
    tmks_pkg::corner_t m_corner;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_ix = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (cfg_wr)
        begin
            case (reg_ix)
                tmks_pkg::REG_IMAGE_WIDTH:
                begin
                    cfg_next.image_width = pwdata[tmks_pkg::DIM_W-1:0];
                    restart = 1'b1;
                end
                tmks_pkg::REG_IMAGE_HEIGHT:
                begin
                    cfg_next.image_height = pwdata[tmks_pkg::DIM_W-1:0];
                    restart = 1'b1;
                end
                tmks_pkg::REG_TILE_SIZE:
                begin
                    cfg_next.tile_size = pwdata[tmks_pkg::TILE_W-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_ix)
            tmks_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_reg.image_width);
            tmks_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_reg.image_height);
            tmks_pkg::REG_TILE_SIZE:    prdata = 32'(cfg_reg.tile_size);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= tmks_pkg::WIDTH_RESET;
            cfg_reg.image_height <= tmks_pkg::HEIGHT_RESET;
            cfg_reg.tile_size    <= tmks_pkg::TILE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tmks_front #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_HEIGHT       (MAX_HEIGHT),
        .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .restart  (restart),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .push     (push),
        .push_idx (push_idx),
        .push_pix (push_pix)
    );

    tmks_queue #(
        .DATA_W (QW),
        .DEPTH  (tmks_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_idx, push_pix}),
        .ready     (q_ready),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign q_idx = q_data[QW-1 -: IW];
    assign q_pix = q_data[$bits(tmks_pkg::pix_t)-1:0];

    tmks_back #(
        .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_idx    (q_idx),
        .q_pix    (q_pix),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_corner)
    );

    assign m_tdata = m_corner;

endmodule

`default_nettype wire

// ===== tb/tb_tile_maximum_keypoint_select.sv =====
// testbench for tile_maximum_keypoint_select: apb register setup, pixel stream in,
// corner stream out, each corner checked against a tile-maximum predictor
// depends on tmks_pkg and the rtl of the block

// tracks the tile maxima of the frame and holds the corners still to come
class tile_corner_board;
    localparam int TILE_SLOTS = 512;
    localparam int FRAME_MAX  = 4096;

    logic [tmks_pkg::DIM_W-1:0]   width_reg;
    logic [tmks_pkg::DIM_W-1:0]   height_reg;
    logic [tmks_pkg::TILE_W-1:0]  tile_reg;
    int unsigned                  col;
    int unsigned                  row;
    int unsigned                  col_in_tile;
    int unsigned                  row_in_tile;
    int unsigned                  tile_col;
    logic [tmks_pkg::RESP_W-1:0]  best_value [TILE_SLOTS];
    logic [tmks_pkg::COORD_W-1:0] best_x [TILE_SLOTS];
    logic [tmks_pkg::COORD_W-1:0] best_y [TILE_SLOTS];
    tmks_pkg::corner_t            due_corners [$];
    int                           errors;

    function new();
        width_reg  = tmks_pkg::WIDTH_RESET;
        height_reg = tmks_pkg::HEIGHT_RESET;
        tile_reg   = tmks_pkg::TILE_RESET;
        errors     = 0;
        foreach (best_value[i])
        begin
            best_value[i] = '0;
            best_x[i]     = '0;
            best_y[i]     = '0;
        end
        rewind();
    endfunction

    function void rewind();
        col         = 0;
        row         = 0;
        col_in_tile = 0;
        row_in_tile = 0;
        tile_col    = 0;
    endfunction

    function int unsigned frame_width();
        if (width_reg == 0)
            return 1;
        return (width_reg > FRAME_MAX) ? FRAME_MAX : width_reg;
    endfunction

    function int unsigned frame_height();
        if (height_reg == 0)
            return 1;
        return (height_reg > FRAME_MAX) ? FRAME_MAX : height_reg;
    endfunction

    function int unsigned tile_side();
        if (tile_reg < tmks_pkg::TILE_MIN)
            return tmks_pkg::TILE_MIN;
        return (tile_reg > tmks_pkg::TILE_MAX) ? tmks_pkg::TILE_MAX : tile_reg;
    endfunction

    // any known register restarts the frame, other indexes change nothing
    function void write_register(logic [tmks_pkg::REG_IX_W-1:0] ix, logic [31:0] value);
        case (ix)
            tmks_pkg::REG_IMAGE_WIDTH:  width_reg  = value[tmks_pkg::DIM_W-1:0];
            tmks_pkg::REG_IMAGE_HEIGHT: height_reg = value[tmks_pkg::DIM_W-1:0];
            tmks_pkg::REG_TILE_SIZE:    tile_reg   = value[tmks_pkg::TILE_W-1:0];
            default:                    return;
        endcase
        rewind();
    endfunction

    function void take_pixel(logic [tmks_pkg::RESP_W-1:0] resp);
        int unsigned       w;
        int unsigned       h;
        int unsigned       t;
        int unsigned       slot;
        bit                row_end;
        bit                tcol_end;
        bit                bottom;
        bit                trow_end;
        tmks_pkg::corner_t c;
        w    = frame_width();
        h    = frame_height();
        t    = tile_side();
        slot = (tile_col < TILE_SLOTS) ? tile_col : TILE_SLOTS - 1;
        if (row_in_tile == 0 && col_in_tile == 0)
            best_value[slot] = '0;
        // strictly greater keeps the first of equal maxima
        if (resp > best_value[slot])
        begin
            best_value[slot] = resp;
            best_x[slot]     = tmks_pkg::COORD_W'(col);
            best_y[slot]     = tmks_pkg::COORD_W'(row);
        end
        row_end  = (col + 1 >= w);
        tcol_end = row_end || (col_in_tile + 1 >= t);
        bottom   = (row + 1 >= h);
        trow_end = bottom || (row_in_tile + 1 >= t);
        if (tcol_end && trow_end && best_value[slot] != 0)
        begin
            c.x        = best_x[slot];
            c.y        = best_y[slot];
            c.strength = best_value[slot];
            due_corners = {due_corners, c};
        end
        if (row_end)
        begin
            col         = 0;
            col_in_tile = 0;
            tile_col    = 0;
            if (bottom)
            begin
                row         = 0;
                row_in_tile = 0;
            end
            else
            begin
                row++;
                row_in_tile = trow_end ? 0 : row_in_tile + 1;
            end
        end
        else
        begin
            col++;
            if (tcol_end)
            begin
                col_in_tile = 0;
                tile_col++;
            end
            else
                col_in_tile++;
        end
    endfunction

    function void check_corner(logic [39:0] word);
        tmks_pkg::corner_t got;
        tmks_pkg::corner_t want;
        got = word;
        if (due_corners.size() == 0)
        begin
            $error("unexpected corner x=%0d y=%0d strength=%0d", got.x, got.y, got.strength);
            errors++;
            return;
        end
        want = due_corners.pop_front();
        if (got.x !== want.x)
        begin
            $error("corner_x: expected %0d, actual %0d", want.x, got.x);
            errors++;
        end
        if (got.y !== want.y)
        begin
            $error("corner_y: expected %0d, actual %0d", want.y, got.y);
            errors++;
        end
        if (got.strength !== want.strength)
        begin
            $error("corner_strength: expected %0d, actual %0d", want.strength, got.strength);
            errors++;
        end
    endfunction
endclass

module tb_tile_maximum_keypoint_select;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_IX_W = tmks_pkg::REG_IX_W;
    localparam int ADDR_W   = tmks_pkg::ADDR_W;
    localparam int RESP_W   = tmks_pkg::RESP_W;
    localparam logic [REG_IX_W-1:0] REG_IMAGE_WIDTH  = tmks_pkg::REG_IMAGE_WIDTH;
    localparam logic [REG_IX_W-1:0] REG_IMAGE_HEIGHT = tmks_pkg::REG_IMAGE_HEIGHT;
    localparam logic [REG_IX_W-1:0] REG_TILE_SIZE    = tmks_pkg::REG_TILE_SIZE;

    localparam logic [REG_IX_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 650;
    localparam int CALM_FROM    = 560;
    localparam int LONG_HOLD    = 80;

    typedef enum int {SPARSE, TIES, NOISE, EDGES} flavor_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;    // [15:0] response
    logic              m_tvalid;
    logic              m_tready;
    logic [39:0]       m_tdata;    // [11:0] corner_x, [23:12] corner_y,
                                   // [39:24] corner_strength

    tile_corner_board board;
    bit               calm;
    int               hold_request;
    int               quiet_cycles;
    int               pixels_sent;

    tile_maximum_keypoint_select dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic [RESP_W-1:0] pick_response(flavor_t flavor);
        case (flavor)
            SPARSE:  return ($urandom_range(0, 7) == 0) ? RESP_W'($urandom) : '0;
            TIES:    return RESP_W'($urandom_range(0, 3));
            NOISE:   return RESP_W'($urandom);
            default:
                case ($urandom_range(0, 5))
                    0:       return 16'h0000;
                    1:       return 16'h0001;
                    2:       return 16'h7FFF;
                    3:       return 16'h8000;
                    4:       return 16'hFFFE;
                    default: return 16'hFFFF;
                endcase
        endcase
    endfunction

    function automatic logic [31:0] pick_dim(int unsigned top);
        case ($urandom_range(0, 9))
            0:       return 32'($urandom_range(0, 1));
            1:       return $urandom;
            default: return 32'($urandom_range(1, top));
        endcase
    endfunction

    function automatic logic [31:0] pick_tile();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 7));
            2:       return 32'($urandom_range(65, 127));
            3:       return 32'd64;
            4:       return 32'($urandom_range(17, 63));
            default: return 32'($urandom_range(8, 16));
        endcase
    endfunction

    task automatic write_reg(input logic [REG_IX_W-1:0] ix, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ix, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.write_register(ix, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every due corner, then let pixels without a corner clear the pipe
    task automatic drain_corners();
        while (board.due_corners.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [RESP_W-1:0] resp);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= resp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.take_pixel(resp);
    endtask

    task automatic stream(input logic [RESP_W-1:0] values[$]);
        foreach (values[i])
        begin
            // now and then the sender waits for every corner to come back
            if (i > 0 && !calm && $urandom_range(0, 99) == 0)
            begin
                s_tvalid <= 1'b0;
                drain_corners();
            end
            send_pixel(values[i]);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random short stalls plus one long hold when asked
    initial
    begin : sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (m_tvalid && m_tready)
                board.check_corner(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_tile_maximum_keypoint_select: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [RESP_W-1:0] batch [$];
        int unsigned       area;
        int                n;
        int                room;
        int                phase;
        flavor_t           flavor;
        board        = new();
        calm         = 1'b0;
        hold_request = 0;
        pixels_sent  = 0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial row under the reset geometry, dropped by the first write
        batch = {16'd9, 16'hFFFF, 16'd0};
        stream(batch);
        drain_corners();

        // 3x2 frame in one clipped tile, equal maxima keep the first
        write_reg(REG_IMAGE_WIDTH, 32'd3);
        write_reg(REG_IMAGE_HEIGHT, 32'd2);
        write_reg(REG_TILE_SIZE, 32'd8);
        batch = {16'd0, 16'hFFFF, 16'hFFFF, 16'd5, 16'd0, 16'd1};
        stream(batch);
        // a tile of zeros reports nothing
        batch = {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        stream(batch);
        batch = {16'd0, 16'd7};
        stream(batch);
        drain_corners();
        // unknown register: the frame goes on where it was
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        batch = {16'd7, 16'd0, 16'd3, 16'd2};
        stream(batch);
        drain_corners();

        // zero geometry saturates to 1x1 frames with tiles of eight
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        write_reg(REG_IMAGE_HEIGHT, 32'd0);
        write_reg(REG_TILE_SIZE, 32'd0);
        batch = {16'd0, 16'd1, 16'h8000, 16'hFFFF};
        stream(batch);
        drain_corners();

        // a corner per pixel while the result side holds off: input must stall
        hold_request = LONG_HOLD;
        batch = {};
        repeat (40) batch = {batch, pick_response(NOISE)};
        stream(batch);
        pixels_sent += 40;
        drain_corners();

        phase = 0;
        while (pixels_sent < RANDOM_ITEMS)
        begin
            calm = (pixels_sent >= CALM_FROM);
            if (phase == 4)
            begin
                // start of the widest row, then of the tallest column
                write_reg(REG_TILE_SIZE, 32'd8);
                write_reg(REG_IMAGE_WIDTH, 32'd4096);
                write_reg(REG_IMAGE_HEIGHT, 32'd1);
                batch = {};
                repeat (96) batch = {batch, pick_response(SPARSE)};
                stream(batch);
                pixels_sent += 96;
                drain_corners();
                write_reg(REG_TILE_SIZE, 32'd64);
                write_reg(REG_IMAGE_WIDTH, 32'd1);
                write_reg(REG_IMAGE_HEIGHT, 32'h1FFF);
                batch = {};
                repeat (160) batch = {batch, pick_response(NOISE)};
                stream(batch);
                pixels_sent += 160;
                drain_corners();
                calm = (pixels_sent >= CALM_FROM);
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_WIDTH, pick_dim(40));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(REG_IMAGE_HEIGHT, pick_dim(24));
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(REG_TILE_SIZE, pick_tile());
            area = board.frame_width() * board.frame_height();
            n    = area * $urandom_range(1, 2);
            // often stop inside a frame so the next write drops a partial tile
            if ($urandom_range(0, 1) == 1)
                n += $urandom_range(0, area - 1);
            if (n > 240)
                n = $urandom_range(60, 240);
            // no batch runs past the calm point or the item count
            room = calm ? (RANDOM_ITEMS - pixels_sent) : (CALM_FROM - pixels_sent);
            if (n > room)
                n = room;
            if (n < 1)
                n = 1;
            flavor = flavor_t'($urandom_range(0, 3));
            batch  = {};
            repeat (n) batch = {batch, pick_response(flavor)};
            stream(batch);
            pixels_sent += n;
            drain_corners();
            phase++;
        end

        calm = 1'b1;
        drain_corners();
        if (board.errors == 0 && board.due_corners.size() == 0)
            $display("tb_tile_maximum_keypoint_select: PASS");
        else
            $display("tb_tile_maximum_keypoint_select: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/tmks_pkg.sv
rtl/tmks_ram.sv
rtl/tmks_queue.sv
rtl/tmks_front.sv
rtl/tmks_back.sv
rtl/tile_maximum_keypoint_select.sv
tb/tb_tile_maximum_keypoint_select.sv
